[sv/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/lprl_pkg.sv]
`default_nettype none

package lprl_pkg;

    localparam int ADDR_W    = 32;
    localparam int PREFIX_W  = 6;
    localparam int METRIC_W  = 32;
    localparam int IFINDEX_W = 8;
    localparam int SLOT_W    = 4;

    localparam logic [PREFIX_W-1:0] PREFIX_MAX = 6'd32;

    // Request type codes.
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // One stored route entry.
    typedef struct packed {
        logic [ADDR_W-1:0]    destination;
        logic [PREFIX_W-1:0]  mask_len;
        logic [METRIC_W-1:0]  metric;
        logic [IFINDEX_W-1:0] ifindex;
        logic [ADDR_W-1:0]    gateway;
    } entry_t;

    // One result word.
    typedef struct packed {
        logic                 found;
        logic [SLOT_W-1:0]    best_slot;
        logic [IFINDEX_W-1:0] ifindex;
        logic [ADDR_W-1:0]    gateway;
        logic [PREFIX_W-1:0]  mask_len;
        logic [METRIC_W-1:0]  metric;
    } rsp_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic write_en;
        logic issue;
        logic result_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic idx_last;
        logic out_full;
    } ctrl_status_t;

    // Network mask with plen leading ones; plen is at most 32.
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PREFIX_W-1:0] plen);
        logic [ADDR_W-1:0] ones;
        ones = '1;
        return ~(ones >> plen);
    endfunction

endpackage

`default_nettype wire

[sv/lprl_if.sv]
`default_nettype none

// Request channel: one word is a table write or an address lookup.
interface lprl_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [3:0]  slot;
    logic        slot_valid;
    logic [31:0] route_destination;
    logic [5:0]  route_prefix_len;
    logic [31:0] route_metric;
    logic [7:0]  route_ifindex;
    logic [31:0] route_gateway;
    logic [31:0] lookup_address;

    modport source (
        output valid, req_type, slot, slot_valid, route_destination, route_prefix_len,
               route_metric, route_ifindex, route_gateway, lookup_address,
        input  ready
    );

    modport sink (
        input  valid, req_type, slot, slot_valid, route_destination, route_prefix_len,
               route_metric, route_ifindex, route_gateway, lookup_address,
        output ready
    );
endinterface

// Response channel: one word per request.
interface lprl_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [3:0]  best_slot;
    logic [7:0]  out_ifindex;
    logic [31:0] out_gateway;
    logic [5:0]  out_prefix_len;
    logic [31:0] out_metric;

    modport source (
        output valid, found, best_slot, out_ifindex, out_gateway, out_prefix_len,
               out_metric,
        input  ready
    );

    modport sink (
        input  valid, found, best_slot, out_ifindex, out_gateway, out_prefix_len,
               out_metric,
        output ready
    );
endinterface

`default_nettype wire

[sv/longest_prefix_route_lookup.sv]
// Write word: the entry is written on acceptance, then the result loads from the DONE state
// once the output register is free. Lookup word: the scan (SCAN, FLUSH) runs before DONE;
// either way the next word is accepted once the result has loaded.
// The lookup time is set by the scan: one entry-memory read and one compare per cycle.
// Reset (rst_n, asynchronous, active low) clears all entry valid bits and the handshake
// state at once; there is no clearing pass and the block is ready right after reset.
`default_nettype none

module longest_prefix_route_lookup #(
    parameter int TABLE_DEPTH = 16
) (
    input wire logic  clk,
    input wire logic  rst_n,
    lprl_req_if.sink  req,
    lprl_rsp_if.source rsp
);

    lprl_pkg::ctrl_cmd_t    cmd;
    lprl_pkg::ctrl_status_t status;
    lprl_pkg::rsp_word_t    out_word;
    logic                   in_ready;
    logic                   out_valid;

    // Sequencer for write, scan and result hand-off.
    lprl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_type   (req.req_type),
        .out_ready (rsp.ready),
        .status    (status),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    // Route table, scan compare and output register.
    lprl_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .slot              (req.slot),
        .slot_valid        (req.slot_valid),
        .route_destination (req.route_destination),
        .route_prefix_len  (req.route_prefix_len),
        .route_metric      (req.route_metric),
        .route_ifindex     (req.route_ifindex),
        .route_gateway     (req.route_gateway),
        .lookup_address    (req.lookup_address),
        .out_ready         (rsp.ready),
        .out_valid         (out_valid),
        .out_word          (out_word)
    );

    // Channel connections.
    assign req.ready          = in_ready;
    assign rsp.valid          = out_valid;
    assign rsp.found          = out_word.found;
    assign rsp.best_slot      = out_word.best_slot;
    assign rsp.out_ifindex    = out_word.ifindex;
    assign rsp.out_gateway    = out_word.gateway;
    assign rsp.out_prefix_len = out_word.mask_len;
    assign rsp.out_metric     = out_word.metric;

endmodule

`default_nettype wire

[sv/lprl_ctrl.sv]
`default_nettype none

module lprl_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_type,
    input  wire logic                  out_ready,
    input  wire lprl_pkg::ctrl_status_t status,
    output logic                       in_ready,
    output lprl_pkg::ctrl_cmd_t        cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   out_free;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !status.out_full || out_ready;

    // Next state and datapath commands.
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    if (in_type == lprl_pkg::REQ_LOOKUP)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        cmd.write_en = 1'b1;
                        state_next   = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (status.idx_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                // The last entry read is compared in this cycle.
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[sv/lprl_datapath.sv]
`default_nettype none

module lprl_datapath #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lprl_pkg::ctrl_cmd_t   cmd,
    output lprl_pkg::ctrl_status_t     status,
    input  wire logic [3:0]            slot,
    input  wire logic                  slot_valid,
    input  wire logic [31:0]           route_destination,
    input  wire logic [5:0]            route_prefix_len,
    input  wire logic [31:0]           route_metric,
    input  wire logic [7:0]            route_ifindex,
    input  wire logic [31:0]           route_gateway,
    input  wire logic [31:0]           lookup_address,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output lprl_pkg::rsp_word_t        out_word
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Entry storage and per-entry valid bits.
    lprl_pkg::entry_t entry_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;

    // Scan state.
    logic [IDX_W-1:0]           idx_reg;
    logic                       cmp_pend_reg;
    lprl_pkg::entry_t           rd_entry_reg;
    logic                       rd_valid_reg;
    logic [IDX_W-1:0]           rd_idx_reg;
    logic [lprl_pkg::ADDR_W-1:0] addr_reg;

    // Best match so far.
    logic                       have_reg;
    lprl_pkg::entry_t           best_entry_reg;
    logic [IDX_W-1:0]           best_idx_reg;

    // Output register.
    logic                       out_valid_reg;
    lprl_pkg::rsp_word_t        out_word_reg;

    lprl_pkg::entry_t           wr_entry;
    logic [IDX_W-1:0]           wr_addr;
    logic                       wr_in_range;
    logic                       hit;
    logic                       better;

    // Write word with the prefix length saturated to a full mask.
    always_comb
    begin
        wr_entry.destination = route_destination;
        wr_entry.mask_len    = (route_prefix_len > lprl_pkg::PREFIX_MAX) ?
                               lprl_pkg::PREFIX_MAX : route_prefix_len;
        wr_entry.metric      = route_metric;
        wr_entry.ifindex     = route_ifindex;
        wr_entry.gateway     = route_gateway;
    end

    assign wr_addr     = IDX_W'(slot);
    assign wr_in_range = (9'(slot) < 9'(TABLE_DEPTH));

    // Entry memory: one write port, one registered read port for the scan.
    always_ff @(posedge clk)
    begin
        if (cmd.write_en && wr_in_range)
        begin
            entry_mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            rd_entry_reg <= entry_mem[idx_reg];
            rd_idx_reg   <= idx_reg;
        end
    end

    // Valid bits are cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.write_en && wr_in_range)
        begin
            valid_reg[wr_addr] <= slot_valid;
        end
    end

    // Scan counter and compare-pending flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            cmp_pend_reg <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_pend_reg <= cmd.issue;
            if (cmd.capture)
            begin
                idx_reg <= '0;
            end
            else if (cmd.issue)
            begin
                idx_reg      <= idx_reg + IDX_W'(1);
                rd_valid_reg <= valid_reg[idx_reg];
            end
        end
    end

    assign status.idx_last = (idx_reg == IDX_W'(TABLE_DEPTH - 1));
    assign status.out_full = out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg <= lookup_address;
        end
    end

    // Compare the entry read in the previous cycle against the best so far.
    assign hit = cmp_pend_reg && rd_valid_reg &&
                 ((addr_reg & lprl_pkg::prefix_mask(rd_entry_reg.mask_len)) ==
                  rd_entry_reg.destination);

    assign better = !have_reg ||
                    (rd_entry_reg.mask_len > best_entry_reg.mask_len) ||
                    ((rd_entry_reg.mask_len == best_entry_reg.mask_len) &&
                     (rd_entry_reg.metric < best_entry_reg.metric));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            have_reg <= 1'b0;
        end
        else if (hit && better)
        begin
            have_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit && better)
        begin
            best_entry_reg <= rd_entry_reg;
            best_idx_reg   <= rd_idx_reg;
        end
    end

    // Output register; a new result may load while the old one is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            if (have_reg)
            begin
                out_word_reg.found     <= 1'b1;
                out_word_reg.best_slot <= lprl_pkg::SLOT_W'(best_idx_reg);
                out_word_reg.ifindex   <= best_entry_reg.ifindex;
                out_word_reg.gateway   <= best_entry_reg.gateway;
                out_word_reg.mask_len  <= best_entry_reg.mask_len;
                out_word_reg.metric    <= best_entry_reg.metric;
            end
            else
            begin
                out_word_reg <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

`default_nettype wire

[sv/lprl_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module lprl_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic        found,
    input wire logic [3:0]  best_slot,
    input wire logic [7:0]  out_ifindex,
    input wire logic [31:0] out_gateway,
    input wire logic [5:0]  out_prefix_len,
    input wire logic [31:0] out_metric
);

    // All result fields side by side.
    logic [82:0] rsp_fields;

    assign rsp_fields = {found, best_slot, out_ifindex, out_gateway, out_prefix_len,
                         out_metric};

    // A stalled response word stays offered.
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)

    // A stalled response word keeps its result.
    `ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready, $stable(rsp_fields))

    // The block works on one request at a time, so it is busy right after an acceptance.
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req_valid && req_ready, !req_ready)

    // A miss or a write reports all fields as zero.
    `ASSERT_IMPLIES(a_miss_zero, clk, rst_n, rsp_valid && !found, rsp_fields == '0)

    // A hit never reports a prefix longer than a full address.
    `ASSERT_IMPLIES(a_hit_prefix, clk, rst_n, rsp_valid && found, out_prefix_len <= 6'd32)

endmodule

bind longest_prefix_route_lookup lprl_checker u_lprl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .found          (rsp.found),
    .best_slot      (rsp.best_slot),
    .out_ifindex    (rsp.out_ifindex),
    .out_gateway    (rsp.out_gateway),
    .out_prefix_len (rsp.out_prefix_len),
    .out_metric     (rsp.out_metric)
);

`default_nettype wire
